@@ hw/rtl/lrjc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar range-jump clustering: shared types and constants
// Item layouts, register indexes and the command format passed from the
// classifying front end to the result back end.
// ----------------------------------------------------------------------------
package lrjc_pkg;

  localparam int RANGE_BITS    = 16;
  localparam int THR_BITS      = 16;
  localparam int MIN_BITS      = 13;
  localparam int START_BITS    = 12;
  localparam int LEN_BITS      = 13;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  localparam int MAX_RES       = 3;
  localparam int NRES_BITS     = 2;

  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_BITS = 2;
  localparam int CMDQ_CNT_BITS = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_DISTANCE_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_CLUSTER_SIZE   = 1'b1;

  localparam logic [THR_BITS-1:0] THR_RESET = 16'd100;
  localparam logic [MIN_BITS-1:0] MIN_RESET = 13'd3;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_mm;
    logic                  last_sample;
  } in_item_t;

  typedef struct packed {
    logic                  cluster_valid;
    logic [START_BITS-1:0] cluster_start;
    logic [LEN_BITS-1:0]   cluster_length;
    logic                  wraps_around;
    logic                  end_of_scan;
    logic                  scan_too_long;
  } out_item_t;

  // One accepted sample's worth of results, in output order from slot 0.
  typedef struct packed {
    logic [NRES_BITS-1:0]      n;
    out_item_t [MAX_RES-1:0]   res;
  } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/lidar_range_jump_clustering_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar range-jump clustering: top level
// Segments a circular lidar scan into clusters at range jumps.
// ----------------------------------------------------------------------------
// Samples enter one per clock through push/full and are classified in the
// cycle they are accepted: one absolute range difference against the
// previous sample and a compare with distance_threshold decide whether the
// sample extends the current cluster. Each sample yields zero to three
// results (a closed middle cluster, and on the last sample the final cluster,
// merged across the wrap when close, followed by the held first cluster, or a
// bare end marker when nothing qualifies). These travel as one command
// through a four-deep queue to the back end, which hands results out one per
// clock through the output register. The input side therefore sustains one
// sample per cycle while the result side keeps up; a sample with several
// results occupies the result port until they drain; the queue absorbs bursts.
// Samples beyond MAX_SAMPLES in one scan are dropped and flag scan_too_long.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module lidar_range_jump_clustering_top #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [lrjc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [lrjc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // sample input
  input  wire logic                               push,
  output logic                                    full,
  input  wire lrjc_pkg::in_item_t                 in_item,
  // result output
  output logic                                    empty,
  input  wire logic                               pop,
  output lrjc_pkg::out_item_t                     out_item
);
  import lrjc_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic q_vld;
  logic q_full;
  logic q_rd;

  // Take a sample whenever the command queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  lrjc_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_item   (in_item),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  lrjc_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd),
    .rd    (q_rd),
    .rdata (head),
    .vld   (q_vld),
    .full  (q_full)
  );

  lrjc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_vld    (q_vld),
    .head     (head),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

@@ hw/rtl/lrjc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar range-jump clustering: front end
// Holds the scan state and registers, classifies each sample and emits a
// command with the qualifying results it causes, or a bare end marker.
// ----------------------------------------------------------------------------
module lrjc_front #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [lrjc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [lrjc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic                               accept,
  input  wire lrjc_pkg::in_item_t                 in_item,
  output logic                                    cmd_push,
  output lrjc_pkg::cmd_t                          cmd
);
  import lrjc_pkg::*;

  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CW + 1 > LEN_BITS) ? CW + 1 : LEN_BITS;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

  logic [THR_BITS-1:0]   thr;
  logic [MIN_BITS-1:0]   min_size;

  logic [RANGE_BITS-1:0] prev_range, prev_range_next;
  logic [RANGE_BITS-1:0] first_range, first_range_next;
  logic [CW-1:0]         cur_start, cur_start_next;
  logic [CW-1:0]         cur_len, cur_len_next;
  logic [CW-1:0]         held_len, held_len_next;
  logic                  held, held_next;
  logic                  ovf_seen, ovf_seen_next;

  logic [CW-1:0]         count;
  logic                  is_ovf;
  logic [RANGE_BITS-1:0] jump, wrap_jump;
  logic                  joins, close;
  logic                  mid;
  logic [CMP_W-1:0]      min_ext, len_a;
  logic [2:0]            qual;
  out_item_t [2:0]       cand;
  out_item_t [MAX_RES-1:0] res;
  logic [NRES_BITS-1:0]  slot;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= THR_RESET;
      min_size <= MIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DISTANCE_THRESHOLD: thr      <= cfg_wdata[THR_BITS-1:0];
        REG_MIN_CLUSTER_SIZE:   min_size <= cfg_wdata[MIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Classify the sample and work out the next scan state
  always_comb begin
    prev_range_next  = prev_range;
    first_range_next = first_range;
    cur_start_next   = cur_start;
    cur_len_next     = cur_len;
    held_len_next    = held_len;
    held_next        = held;
    ovf_seen_next    = ovf_seen;
    mid              = 1'b0;

    count  = (cur_len == '0) ? '0 : CW'(cur_start + cur_len);
    is_ovf = (count >= MAX_C);
    jump   = (in_item.range_mm > prev_range) ? in_item.range_mm - prev_range
                                             : prev_range - in_item.range_mm;
    joins  = (jump < thr);

    if (is_ovf) begin
      ovf_seen_next = 1'b1;
    end else if (count == '0) begin
      first_range_next = in_item.range_mm;
      prev_range_next  = in_item.range_mm;
      cur_start_next   = '0;
      cur_len_next     = CW'(1);
    end else begin
      if (joins) begin
        cur_len_next = CW'(cur_len + CW'(1));
      end else begin
        if (!held) begin
          held_len_next = cur_len;
          held_next     = 1'b1;
        end else begin
          mid = 1'b1;
        end
        cur_start_next = count;
        cur_len_next   = CW'(1);
      end
      prev_range_next = in_item.range_mm;
    end

    wrap_jump = (first_range_next > prev_range_next) ? first_range_next - prev_range_next
                                                     : prev_range_next - first_range_next;
    close   = held_next && (wrap_jump < thr);
    min_ext = CMP_W'(min_size);
    len_a   = close ? CMP_W'(cur_len_next) + CMP_W'(held_len_next) : CMP_W'(cur_len_next);

    // Middle cluster that just closed
    cand[0].cluster_valid  = 1'b1;
    cand[0].cluster_start  = START_BITS'(CMP_W'(cur_start));
    cand[0].cluster_length = LEN_BITS'(CMP_W'(cur_len));
    cand[0].wraps_around   = 1'b0;
    cand[0].end_of_scan    = 1'b0;
    cand[0].scan_too_long  = ovf_seen_next;
    // Final cluster, merged across the wrap when close
    cand[1].cluster_valid  = 1'b1;
    cand[1].cluster_start  = START_BITS'(CMP_W'(cur_start_next));
    cand[1].cluster_length = len_a[LEN_BITS-1:0];
    cand[1].wraps_around   = close;
    cand[1].end_of_scan    = 1'b0;
    cand[1].scan_too_long  = ovf_seen_next;
    // Held first cluster, reported last
    cand[2].cluster_valid  = 1'b1;
    cand[2].cluster_start  = '0;
    cand[2].cluster_length = LEN_BITS'(CMP_W'(held_len_next));
    cand[2].wraps_around   = 1'b0;
    cand[2].end_of_scan    = 1'b0;
    cand[2].scan_too_long  = ovf_seen_next;

    qual[0] = mid && (CMP_W'(cur_len) >= min_ext);
    qual[1] = in_item.last_sample && (len_a >= min_ext);
    qual[2] = in_item.last_sample && held_next && !close &&
              (CMP_W'(held_len_next) >= min_ext);

    // Pack qualifying results into the lowest slots, in order
    res  = '0;
    slot = '0;
    for (int i = 0; i < 3; i++) begin
      if (qual[i]) begin
        res[slot] = cand[i];
        slot      = NRES_BITS'(slot + NRES_BITS'(1));
      end
    end
    if (in_item.last_sample && slot == '0) begin
      res[0].scan_too_long = ovf_seen_next;
      slot                 = NRES_BITS'(1);
    end
    if (in_item.last_sample) begin
      res[NRES_BITS'(slot - NRES_BITS'(1))].end_of_scan = 1'b1;
    end

    cmd.n    = slot;
    cmd.res  = res;
    cmd_push = accept && (slot != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_item.last_sample)) begin
      prev_range  <= '0;
      first_range <= '0;
      cur_start   <= '0;
      cur_len     <= '0;
      held_len    <= '0;
      held        <= 1'b0;
      ovf_seen    <= 1'b0;
    end else if (accept) begin
      prev_range  <= prev_range_next;
      first_range <= first_range_next;
      cur_start   <= cur_start_next;
      cur_len     <= cur_len_next;
      held_len    <= held_len_next;
      held        <= held_next;
      ovf_seen    <= ovf_seen_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lrjc_cmdq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar range-jump clustering: command queue
// Short register queue decoupling the front end from the result back end.
// ----------------------------------------------------------------------------
module lrjc_cmdq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire lrjc_pkg::cmd_t wdata,
  input  wire logic           rd,
  output lrjc_pkg::cmd_t      rdata,
  output logic                vld,
  output logic                full
);
  import lrjc_pkg::*;

  cmd_t                     mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_BITS-1:0] wptr;
  logic [CMDQ_PTR_BITS-1:0] rptr;
  logic [CMDQ_CNT_BITS-1:0] cnt;

  assign vld   = (cnt != '0);
  assign full  = (cnt == CMDQ_CNT_BITS'(CMDQ_DEPTH));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) wptr <= CMDQ_PTR_BITS'(wptr + CMDQ_PTR_BITS'(1));
      if (rd) rptr <= CMDQ_PTR_BITS'(rptr + CMDQ_PTR_BITS'(1));
      case ({wr, rd})
        2'b10:   cnt <= CMDQ_CNT_BITS'(cnt + CMDQ_CNT_BITS'(1));
        2'b01:   cnt <= CMDQ_CNT_BITS'(cnt - CMDQ_CNT_BITS'(1));
        default: cnt <= cnt;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CMDQ_CNT_BITS'(CMDQ_DEPTH))
    else $error("command queue count beyond depth");

  a_cnt_rise: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (cnt == CMDQ_CNT_BITS'($past(cnt) + CMDQ_CNT_BITS'(1))))
    else $error("command queue count did not advance on write");

endmodule
`default_nettype wire

@@ hw/rtl/lrjc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar range-jump clustering: back end
// Walks head command results into output register, one per cycle if popped.
// ----------------------------------------------------------------------------
module lrjc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_vld,
  input  wire lrjc_pkg::cmd_t head,
  output logic                q_rd,
  input  wire logic           pop,
  output logic                empty,
  output lrjc_pkg::out_item_t out_item
);
  import lrjc_pkg::*;

  logic [NRES_BITS-1:0] idx;
  logic                 ov;
  logic                 load;
  logic                 last_of_cmd;

  assign empty       = !ov;
  assign load        = q_vld && (!ov || pop);
  assign last_of_cmd = (idx == NRES_BITS'(head.n - NRES_BITS'(1)));
  assign q_rd        = load && last_of_cmd;

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= head.res[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        ov  <= 1'b1;
        idx <= last_of_cmd ? '0 : NRES_BITS'(idx + NRES_BITS'(1));
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> (head.n != '0))
    else $error("queued command carries no result");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> (idx < head.n))
    else $error("result index past end of command");

  a_marker_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_item.cluster_valid) |-> out_item.end_of_scan)
    else $error("bare marker without end of scan");

endmodule
`default_nettype wire
